[rtl/bps_pkg.sv]
// Shared types, constants and helpers for the Blinn-Phong shader pipeline.
// No dependencies; imported by every module of the block.
package bps_pkg;

  localparam int SQ_STEPS   = 30;
  localparam int DIV_STEPS  = 16;
  localparam int NORM_LAT   = 2 + SQ_STEPS + DIV_STEPS + 1;
  localparam int POW_STEPS  = 8;

  localparam int S_H        = NORM_LAT;
  localparam int S_DOT      = 2 * NORM_LAT + 1;
  localparam int S_SUM      = S_DOT + 1;
  localparam int S_POW0     = S_SUM + 1;
  localparam int S_C1       = S_POW0 + POW_STEPS;
  localparam int S_C5       = S_C1 + 4;
  localparam int PIPE_DEPTH = S_C5 + 1;

  localparam int CFG_AW = 5;

  localparam logic [15:0] ONE_Q14   = 16'd16384;
  localparam logic [31:0] POW_CAP   = 32'hFFFF_FFFF;
  localparam logic [24:0] RECIP_255 = 25'd16843009;
  localparam logic [42:0] SAT_LIM   = 43'd16711680;

  typedef enum logic [2:0] {
    REG_LIGHT_DIR_X = 3'd0,
    REG_LIGHT_DIR_Y = 3'd1,
    REG_LIGHT_DIR_Z = 3'd2,
    REG_LIGHT_RED   = 3'd3,
    REG_LIGHT_GREEN = 3'd4,
    REG_LIGHT_BLUE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec16_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } vec17_t;

  // Q18.14 product, truncated and saturated to 32 bits
  function automatic logic [31:0] mul_q14(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    if (p[63:46] != 18'd0) begin
      return POW_CAP;
    end
    return p[45:14];
  endfunction

endpackage

[rtl/bps_in_if.sv]
// Input channel of the shader: one surface hit per transfer.
// Standalone; valid/ready handshake.
interface bps_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] view_dir_x;
  logic signed [15:0] view_dir_y;
  logic signed [15:0] view_dir_z;
  logic [23:0]        diffuse_rgb;
  logic [23:0]        specular_rgb;
  logic [7:0]         shininess;

  modport source(output valid, normal_x, normal_y, normal_z, view_dir_x, view_dir_y,
                 view_dir_z, diffuse_rgb, specular_rgb, shininess, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, view_dir_x, view_dir_y,
               view_dir_z, diffuse_rgb, specular_rgb, shininess, output ready);
endinterface

[rtl/bps_out_if.sv]
// Result channel of the shader: one shaded RGB color per transfer.
// Standalone; valid/ready handshake.
interface bps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;

  modport source(output valid, out_red, out_green, out_blue, input ready);
  modport sink(input valid, out_red, out_green, out_blue, output ready);
endinterface

[rtl/bps_norm.sv]
// Pipelined vector normalizer: squares, sum, bit-serial square root, restoring division.
// Depends on bps_pkg. Registers advance only while en is high; zero vector gives zero.
module bps_norm import bps_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  vec17_t vec_i,
  output vec16_t unit_o
);

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][15:0] mag;
  } nside_t;

  logic signed [16:0] comp [3];
  logic signed [16:0] abs17 [3];
  logic [2:0][15:0]   mag_in;
  logic [2:0]         neg_in;

  logic [2:0][31:0]   sq_r;
  nside_t             sq_side_r;
  logic [31:0]        sum;

  logic [59:0]        rem_r  [SQ_STEPS+1];
  logic [59:0]        root_r [SQ_STEPS+1];
  nside_t             sd_r   [SQ_STEPS+1];

  logic [2:0][30:0]   drem_in;
  logic [29:0]        len_in;
  logic [2:0][30:0]   drem_r [DIV_STEPS];
  logic [2:0][15:0]   quo_r  [DIV_STEPS];
  logic [29:0]        len_r  [DIV_STEPS];
  nside_t             dd_r   [DIV_STEPS];

  logic [15:0]        ures [3];
  vec16_t             unit_r;

  always_comb begin
    comp[0] = vec_i.x;
    comp[1] = vec_i.y;
    comp[2] = vec_i.z;
    for (int c = 0; c < 3; c++) begin
      neg_in[c] = comp[c][16];
      abs17[c]  = comp[c][16] ? -comp[c] : comp[c];
      mag_in[c] = abs17[c][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= 32'(mag_in[c]) * 32'(mag_in[c]);
      end
      sq_side_r <= '{neg: neg_in, zero: 1'b0, mag: mag_in};
    end
  end

  assign sum = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {sum, 28'd0};
      root_r[0] <= '0;
      sd_r[0]   <= '{neg: sq_side_r.neg, zero: (sum == 32'd0), mag: sq_side_r.mag};
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [59:0] BIT = 60'd1 << (2 * (SQ_STEPS - 1 - k));
    logic [60:0] trial;
    assign trial = {1'b0, root_r[k]} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_r[k]} >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial[59:0];
          root_r[k+1] <= (root_r[k] >> 1) + BIT;
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k] >> 1;
        end
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  always_comb begin
    len_in = root_r[SQ_STEPS][29:0];
    for (int c = 0; c < 3; c++) begin
      drem_in[c] = {3'd0, sd_r[SQ_STEPS].mag[c], 12'd0};
    end
  end

  // one quotient bit per stage, three components side by side
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][30:0] rem_src;
    logic [2:0][15:0] quo_src;
    logic [29:0]      len_src;
    nside_t           side_src;
    if (j == 0) begin : g_first
      assign rem_src  = drem_in;
      assign quo_src  = '0;
      assign len_src  = len_in;
      assign side_src = sd_r[SQ_STEPS];
    end else begin : g_next
      assign rem_src  = drem_r[j-1];
      assign quo_src  = quo_r[j-1];
      assign len_src  = len_r[j-1];
      assign side_src = dd_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          if ({rem_src[c][29:0], 1'b0} >= {1'b0, len_src}) begin
            drem_r[j][c] <= {rem_src[c][29:0], 1'b0} - {1'b0, len_src};
            quo_r[j][c]  <= {quo_src[c][14:0], 1'b1};
          end else begin
            drem_r[j][c] <= {rem_src[c][29:0], 1'b0};
            quo_r[j][c]  <= {quo_src[c][14:0], 1'b0};
          end
        end
        len_r[j] <= len_src;
        dd_r[j]  <= side_src;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dd_r[DIV_STEPS-1].zero) begin
        ures[c] = 16'd0;
      end else if (dd_r[DIV_STEPS-1].neg[c]) begin
        ures[c] = 16'd0 - quo_r[DIV_STEPS-1][c];
      end else begin
        ures[c] = quo_r[DIV_STEPS-1][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= '{x: ures[0], y: ures[1], z: ures[2]};
    end
  end

  assign unit_o = unit_r;

endmodule

[rtl/blinn_phong_shader_core.sv]
// Blinn-Phong shader, one directional light. Pipeline of PIPE_DEPTH stages in all
// (two 49-stage normalizers in series, half-vector add, dot products, 8 power stages, 5 color stages).
// Throughput: one transfer per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n, synchronous): clears all valid bits, loads light (0,1,0) and white.
// Depends on bps_pkg, bps_in_if, bps_out_if, bps_norm.
module blinn_phong_shader_core import bps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bps_in_if.sink            in_ch,
  bps_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef struct packed {
    logic [23:0] dif;
    logic [23:0] spc;
    logic [7:0]  sh;
  } mat_t;

  typedef struct packed {
    vec16_t n;
    mat_t   mat;
  } pay1_t;

  typedef struct packed {
    vec16_t n;
    vec16_t l;
    mat_t   mat;
  } pay2_t;

  logic signed [15:0] light_dir_x_r, light_dir_y_r, light_dir_z_r;
  logic [15:0]        light_red_r, light_green_r, light_blue_r;
  cfg_reg_t           reg_sel;
  logic               cfg_wr;

  logic                  en;
  logic                  acc;
  logic [PIPE_DEPTH-1:0] vld_r;

  vec17_t lvec_in, vvec_in;
  vec16_t l_unit, v_unit, h_unit;
  pay1_t  pay1_in;
  pay1_t  pay1_r [NORM_LAT];
  pay2_t  pay2_r [NORM_LAT+1];
  vec17_t hs_r;

  logic signed [31:0] pl_r [3];
  logic signed [31:0] ph_r [3];
  mat_t               dmat_r;
  logic signed [33:0] sl, sh_sum;
  logic [16:0]        ndl_r, ndh_r;
  mat_t               smat_r;

  logic [31:0] pw_r   [POW_STEPS];
  logic [31:0] base_r [POW_STEPS-1];
  logic [16:0] pndl_r [POW_STEPS];
  mat_t        pmat_r [POW_STEPS];

  logic [2:0][15:0] lc;
  logic [2:0][23:0] dc_r, sc_r;
  logic [31:0]      c1_pw_r;
  logic [16:0]      c1_ndl_r;
  logic [2:0][40:0] ta_r;
  logic [2:0][55:0] tb_r;
  logic [56:0]      num [3];
  logic [42:0]      xq [3];
  logic [2:0][23:0] xs_r, xs4_r;
  logic [2:0]       sat_r, sat4_r;
  logic [48:0]      prod [3];
  logic [2:0][16:0] q0_r;
  logic [24:0]      m255 [3];
  logic [24:0]      rmd [3];
  logic [16:0]      qf [3];
  logic [2:0][15:0] outc_r;

  // ---------------- configuration ----------------
  assign reg_sel = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_dir_x_r <= 16'sd0;
      light_dir_y_r <= 16'sd16384;
      light_dir_z_r <= 16'sd0;
      light_red_r   <= 16'd256;
      light_green_r <= 16'd256;
      light_blue_r  <= 16'd256;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LIGHT_DIR_X: light_dir_x_r <= pwdata[15:0];
        REG_LIGHT_DIR_Y: light_dir_y_r <= pwdata[15:0];
        REG_LIGHT_DIR_Z: light_dir_z_r <= pwdata[15:0];
        REG_LIGHT_RED:   light_red_r   <= pwdata[15:0];
        REG_LIGHT_GREEN: light_green_r <= pwdata[15:0];
        REG_LIGHT_BLUE:  light_blue_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LIGHT_DIR_X: prdata = {16'd0, light_dir_x_r};
      REG_LIGHT_DIR_Y: prdata = {16'd0, light_dir_y_r};
      REG_LIGHT_DIR_Z: prdata = {16'd0, light_dir_z_r};
      REG_LIGHT_RED:   prdata = {16'd0, light_red_r};
      REG_LIGHT_GREEN: prdata = {16'd0, light_green_r};
      REG_LIGHT_BLUE:  prdata = {16'd0, light_blue_r};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign en          = !vld_r[PIPE_DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign acc         = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], acc};
    end
  end

  // ---------------- light and view normalize ----------------
  assign lvec_in = '{x: 17'(light_dir_x_r), y: 17'(light_dir_y_r), z: 17'(light_dir_z_r)};
  assign vvec_in = '{x: -17'(in_ch.view_dir_x), y: -17'(in_ch.view_dir_y),
                     z: -17'(in_ch.view_dir_z)};

  bps_norm u_norm_l (.clk(clk), .en(en), .vec_i(lvec_in), .unit_o(l_unit));
  bps_norm u_norm_v (.clk(clk), .en(en), .vec_i(vvec_in), .unit_o(v_unit));

  assign pay1_in = '{n: '{x: in_ch.normal_x, y: in_ch.normal_y, z: in_ch.normal_z},
                     mat: '{dif: in_ch.diffuse_rgb, spc: in_ch.specular_rgb,
                            sh: in_ch.shininess}};

  always_ff @(posedge clk) begin
    if (en) begin
      pay1_r[0] <= pay1_in;
      for (int k = 1; k < NORM_LAT; k++) begin
        pay1_r[k] <= pay1_r[k-1];
      end
    end
  end

  // ---------------- half vector ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      hs_r <= '{x: 17'(l_unit.x) + 17'(v_unit.x),
                y: 17'(l_unit.y) + 17'(v_unit.y),
                z: 17'(l_unit.z) + 17'(v_unit.z)};
      pay2_r[0] <= '{n: pay1_r[NORM_LAT-1].n, l: l_unit, mat: pay1_r[NORM_LAT-1].mat};
      for (int k = 1; k <= NORM_LAT; k++) begin
        pay2_r[k] <= pay2_r[k-1];
      end
    end
  end

  bps_norm u_norm_h (.clk(clk), .en(en), .vec_i(hs_r), .unit_o(h_unit));

  // ---------------- dot products ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= 32'(pay2_r[NORM_LAT].n.x) * 32'(pay2_r[NORM_LAT].l.x);
      pl_r[1] <= 32'(pay2_r[NORM_LAT].n.y) * 32'(pay2_r[NORM_LAT].l.y);
      pl_r[2] <= 32'(pay2_r[NORM_LAT].n.z) * 32'(pay2_r[NORM_LAT].l.z);
      ph_r[0] <= 32'(pay2_r[NORM_LAT].n.x) * 32'(h_unit.x);
      ph_r[1] <= 32'(pay2_r[NORM_LAT].n.y) * 32'(h_unit.y);
      ph_r[2] <= 32'(pay2_r[NORM_LAT].n.z) * 32'(h_unit.z);
      dmat_r  <= pay2_r[NORM_LAT].mat;
    end
  end

  assign sl     = 34'(pl_r[0]) + 34'(pl_r[1]) + 34'(pl_r[2]);
  assign sh_sum = 34'(ph_r[0]) + 34'(ph_r[1]) + 34'(ph_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      ndl_r  <= (sl > 34'sd0) ? sl[30:14] : 17'd0;
      ndh_r  <= (sh_sum > 34'sd0) ? sh_sum[30:14] : 17'd0;
      smat_r <= dmat_r;
    end
  end

  // ---------------- power, one exponent bit per stage ----------------
  for (genvar i = 0; i < POW_STEPS; i++) begin : g_pow
    logic [31:0] pw_src, base_src;
    logic [16:0] ndl_src;
    mat_t        mat_src;
    if (i == 0) begin : g_first
      assign pw_src   = 32'(ONE_Q14);
      assign base_src = 32'(ndh_r);
      assign ndl_src  = ndl_r;
      assign mat_src  = smat_r;
    end else begin : g_next
      assign pw_src   = pw_r[i-1];
      assign base_src = base_r[i-1];
      assign ndl_src  = pndl_r[i-1];
      assign mat_src  = pmat_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[i]   <= mat_src.sh[i] ? mul_q14(pw_src, base_src) : pw_src;
        pndl_r[i] <= ndl_src;
        pmat_r[i] <= mat_src;
      end
    end
    if (i < POW_STEPS - 1) begin : g_sq
      always_ff @(posedge clk) begin
        if (en) begin
          base_r[i] <= mul_q14(base_src, base_src);
        end
      end
    end
  end

  // ---------------- color ----------------
  assign lc[0] = light_red_r;
  assign lc[1] = light_green_r;
  assign lc[2] = light_blue_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dc_r[c] <= 24'(pmat_r[POW_STEPS-1].dif[8*(2-c) +: 8]) * 24'(lc[c]);
        sc_r[c] <= 24'(pmat_r[POW_STEPS-1].spc[8*(2-c) +: 8]) * 24'(lc[c]);
      end
      c1_pw_r  <= pw_r[POW_STEPS-1];
      c1_ndl_r <= pndl_r[POW_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ta_r[c] <= 41'(dc_r[c]) * 41'(c1_ndl_r);
        tb_r[c] <= 56'(sc_r[c]) * 56'(c1_pw_r);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = 57'(ta_r[c]) + 57'(tb_r[c]);
      xq[c]  = num[c][56:14];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        xs_r[c]  <= xq[c][23:0];
        sat_r[c] <= (xq[c] >= SAT_LIM);
      end
    end
  end

  // divide by 255: reciprocal estimate, then one correction
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = 49'(xs_r[c]) * 49'(RECIP_255);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        q0_r[c] <= prod[c][48:32];
      end
      xs4_r  <= xs_r;
      sat4_r <= sat_r;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      m255[c] = {q0_r[c], 8'd0} - {8'd0, q0_r[c]};
      rmd[c]  = {1'b0, xs4_r[c]} - m255[c];
      qf[c]   = (rmd[c] >= 25'd255) ? q0_r[c] + 17'd1 : q0_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        outc_r[c] <= sat4_r[c] ? 16'hFFFF : qf[c][15:0];
      end
    end
  end

  assign out_ch.valid     = vld_r[PIPE_DEPTH-1];
  assign out_ch.out_red   = outc_r[0];
  assign out_ch.out_green = outc_r[1];
  assign out_ch.out_blue  = outc_r[2];

  // ---------------- assertions ----------------
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.ready && !out_ch.ready) |-> !out_ch.valid)
    else $error("input taken while a blocked result is held");

  a_pow_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_C1-1] && pmat_r[POW_STEPS-1].sh == 8'd0) |->
      (pw_r[POW_STEPS-1] == 32'(ONE_Q14)))
    else $error("zero shininess did not give unit power");

endmodule
